// ===== rtl/facd_pkg.sv =====
// Shared types and constants for the frame and ASCII command deframer.
// Depends on nothing; every other file of the block depends on it.
`default_nettype none

package facd_pkg;

	localparam int unsigned ByteWidth  = 8;
	localparam int unsigned MaxResults = 3;
	localparam int unsigned CountWidth = $clog2(MaxResults + 1);

	localparam logic [ByteWidth-1:0] SlashChar      = 8'h2F;
	localparam logic [ByteWidth-1:0] NewlineChar    = 8'h0A;
	localparam logic [ByteWidth-1:0] FrameStartInit = 8'd126;

	typedef logic [ByteWidth-1:0] byte_t;

	typedef enum logic [2:0] {
		KIND_FRAME       = 3'd0,
		KIND_FRAME_END   = 3'd1,
		KIND_CMD_CHAR    = 3'd2,
		KIND_CMD_DONE    = 3'd3,
		KIND_CMD_DISCARD = 3'd4
	} kind_t;

	typedef struct packed {
		kind_t kind;
		byte_t data_byte;
		logic  last_of_run;
	} result_t;

	// All results caused by one received byte, first result in entry 0.
	typedef struct packed {
		logic [CountWidth-1:0]       count;
		result_t [MaxResults-1:0]    res;
	} group_t;

endpackage

`default_nettype wire

// ===== rtl/facd_if.sv =====
// Valid/ready channel interfaces of the deframer: received bytes, results
// and the start byte register write. Depends on facd_pkg.
`default_nettype none

interface facd_byte_if;
	logic           valid;
	logic           ready;
	facd_pkg::byte_t rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface facd_result_if;
	logic            valid;
	logic            ready;
	facd_pkg::kind_t kind;
	facd_pkg::byte_t data_byte;
	logic            last_of_run;

	modport source (output valid, output kind, output data_byte, output last_of_run,
		input ready);
	modport sink   (input valid, input kind, input data_byte, input last_of_run,
		output ready);
endinterface

interface facd_cfg_if;
	logic            valid;
	logic            ready;
	facd_pkg::byte_t frame_start_value;

	modport source (output valid, output frame_start_value, input ready);
	modport sink   (input valid, input frame_start_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/facd_parser.sv =====
// Input register, parser state and the decode of one byte into a group of
// up to three results. Depends on facd_pkg and facd_if.
`default_nettype none

module facd_parser (
	input  wire logic            clk,
	input  wire logic            arst_n,
	facd_byte_if.sink            rx,
	facd_cfg_if.sink             cfg,
	output facd_pkg::group_t     grp,
	output logic                 grp_valid,
	input  wire logic            grp_ready
);
	import facd_pkg::*;

	localparam logic [1:0] PH_WAIT = 2'd0;
	localparam logic [1:0] PH_LEN  = 2'd1;
	localparam logic [1:0] PH_BODY = 2'd2;

	logic                  valid_s1;
	byte_t                 byte_s1;
	logic                  fire;

	byte_t                 frame_start_q;
	logic                  cmd_open_q;
	logic [1:0]            phase_q;
	byte_t                 len_high_q;
	logic                  len_seen_q;
	logic [15:0]           remaining_q;

	logic                  cmd_open_d;
	logic [1:0]            phase_d;
	byte_t                 len_high_d;
	logic                  len_seen_d;
	logic [15:0]           remaining_d;

	logic                  is_slash;
	logic                  is_newline;
	logic                  cmd_active;
	logic [15:0]           len_full;
	logic [15:0]           rem_dec;
	logic                  frame_v;
	kind_t                 frame_kind;
	result_t [MaxResults-1:0] cand;
	logic [MaxResults-1:0] cand_v;
	logic [CountWidth-1:0] fill;

	assign fire      = valid_s1 && grp_ready;
	assign rx.ready  = !valid_s1 || fire;
	assign grp_valid = valid_s1;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_start_q <= FrameStartInit;
		end else if (cfg.valid && cfg.ready) begin
			frame_start_q <= cfg.frame_start_value;
		end
	end

	// ASCII command parser.
	assign is_slash   = (byte_s1 == SlashChar);
	assign is_newline = (byte_s1 == NewlineChar);
	assign cmd_active = cmd_open_q || is_slash;
	assign cmd_open_d = cmd_active && !is_newline;

	// Binary frame parser.
	assign len_full = {len_high_q, byte_s1};
	assign rem_dec  = remaining_q - 16'd1;

	always_comb begin
		phase_d     = phase_q;
		len_high_d  = len_high_q;
		len_seen_d  = len_seen_q;
		remaining_d = remaining_q;
		frame_v     = 1'b1;
		frame_kind  = KIND_FRAME;
		case (phase_q)
			PH_LEN: begin
				if (!len_seen_q) begin
					len_high_d = byte_s1;
					len_seen_d = 1'b1;
				end else begin
					len_seen_d = 1'b0;
					if (len_full == 16'd0) begin
						phase_d    = PH_WAIT;
						frame_kind = KIND_FRAME_END;
					end else begin
						remaining_d = len_full;
						phase_d     = PH_BODY;
					end
				end
			end
			PH_BODY: begin
				remaining_d = rem_dec;
				if (rem_dec == 16'd0) begin
					phase_d    = PH_WAIT;
					frame_kind = KIND_FRAME_END;
				end
			end
			default: begin
				// The unused phase code behaves as waiting for the start byte.
				if (byte_s1 == frame_start_q) begin
					phase_d    = PH_LEN;
					len_seen_d = 1'b0;
				end else begin
					phase_d = PH_WAIT;
					frame_v = 1'b0;
				end
			end
		endcase
	end

	// Candidates in delivery order: discard mark, command result, frame byte.
	always_comb begin
		cand[0] = '{kind: KIND_CMD_DISCARD, data_byte: '0, last_of_run: 1'b0};
		cand[1] = is_newline
			? '{kind: KIND_CMD_DONE, data_byte: '0, last_of_run: 1'b0}
			: '{kind: KIND_CMD_CHAR, data_byte: byte_s1, last_of_run: 1'b0};
		cand[2] = '{kind: frame_kind, data_byte: byte_s1, last_of_run: 1'b0};
		cand_v  = {frame_v, cmd_active, is_slash && cmd_open_q};
	end

	always_comb begin
		grp.res = '0;
		fill    = '0;
		for (int i = 0; i < MaxResults; i++) begin
			if (cand_v[i]) begin
				grp.res[fill[1:0]] = cand[i];
				fill               = fill + 1'b1;
			end
		end
		for (int i = 0; i < MaxResults; i++) begin
			grp.res[i].last_of_run = (fill != '0) && (CountWidth'(i) == fill - 1'b1);
		end
		grp.count = fill;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_open_q  <= 1'b0;
			phase_q     <= PH_WAIT;
			len_high_q  <= '0;
			len_seen_q  <= 1'b0;
			remaining_q <= '0;
		end else if (fire) begin
			cmd_open_q  <= cmd_open_d;
			phase_q     <= phase_d;
			len_high_q  <= len_high_d;
			len_seen_q  <= len_seen_d;
			remaining_q <= remaining_d;
		end
	end

`ifndef ASSERT_OFF
	a_phase_legal: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != 2'd3)
		else $error("frame phase took the unused code");

	a_seen_in_len: assert property (@(posedge clk) disable iff (!arst_n)
		len_seen_q |-> (phase_q == PH_LEN))
		else $error("length byte flag set outside the length phase");

	a_body_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_BODY) |-> (remaining_q != 16'd0))
		else $error("payload phase with nothing left to receive");
`endif

endmodule

`default_nettype wire

// ===== rtl/facd_emitter.sv =====
// Result register that holds one group and hands its results out one per
// transaction, first entry first. Depends on facd_pkg and facd_if.
`default_nettype none

module facd_emitter (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire facd_pkg::group_t   grp,
	input  wire logic               grp_valid,
	output logic                    grp_ready,
	facd_result_if.source           res
);
	import facd_pkg::*;

	logic [CountWidth-1:0]    count_s2;
	result_t [MaxResults-1:0] res_s2;
	logic                     take;
	logic                     load;

	assign res.valid       = (count_s2 != '0);
	assign res.kind        = res_s2[0].kind;
	assign res.data_byte   = res_s2[0].data_byte;
	assign res.last_of_run = res_s2[0].last_of_run;

	assign take      = res.valid && res.ready;
	assign grp_ready = (count_s2 == '0) || ((count_s2 == CountWidth'(1)) && take);
	assign load      = grp_valid && grp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_s2 <= '0;
		end else if (load) begin
			count_s2 <= grp.count;
		end else if (take) begin
			count_s2 <= count_s2 - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s2 <= grp.res;
		end else if (take) begin
			for (int i = 0; i < MaxResults - 1; i++) begin
				res_s2[i] <= res_s2[i+1];
			end
		end
	end

`ifndef ASSERT_OFF
	a_last_on_final: assert property (@(posedge clk) disable iff (!arst_n)
		(count_s2 == CountWidth'(1)) |-> res_s2[0].last_of_run)
		else $error("final result of a group lacks its end mark");

	a_no_early_last: assert property (@(posedge clk) disable iff (!arst_n)
		(count_s2 > CountWidth'(1)) |-> !res_s2[0].last_of_run)
		else $error("end mark on a result that is not the last of its group");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.ready) |=> (count_s2 == $past(count_s2)))
		else $error("result count moved while the receiver stalled");
`endif

endmodule

`default_nettype wire

// ===== rtl/frame_and_ascii_command_deframer_top.sv =====
// Top level of the frame and ASCII command deframer.
// Depends on facd_pkg, facd_if, facd_parser and facd_emitter.
//
// Channels: rx carries one received byte per transaction; res carries one
// result per transaction (kind, data_byte, last_of_run); cfg writes the byte
// value that opens a binary frame and is always ready.
// Each byte is decoded by a binary frame parser and an ASCII command parser
// side by side and gives zero to three results, ASCII results first; the
// last result of a byte carries last_of_run.
// A byte taken from rx is decoded in the input register, and its results are
// then loaded into the result register, from which the first can be taken.
// Throughput: one byte per cycle while each byte gives at most one result
// and the receiver does not stall. A byte with k results holds the result
// register for k transactions, since the port moves one result in each.
// When the receiver stalls, the result register holds, one more byte waits
// in the input register and rx then drops ready.
// Reset clears both parsers, empties both registers and sets the frame start
// value to 126.
`default_nettype none

module frame_and_ascii_command_deframer_top (
	input  wire logic     clk,
	input  wire logic     arst_n,
	facd_byte_if.sink     rx,
	facd_result_if.source res,
	facd_cfg_if.sink      cfg
);
	import facd_pkg::*;

	group_t grp;
	logic   grp_valid;
	logic   grp_ready;

	facd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx),
		.cfg       (cfg),
		.grp       (grp),
		.grp_valid (grp_valid),
		.grp_ready (grp_ready)
	);

	facd_emitter u_emitter (
		.clk       (clk),
		.arst_n    (arst_n),
		.grp       (grp),
		.grp_valid (grp_valid),
		.grp_ready (grp_ready),
		.res       (res)
	);

endmodule

`default_nettype wire

// ===== dv/tb_frame_and_ascii_command_deframer_top.sv =====
// Self-checking testbench for frame_and_ascii_command_deframer_top: a short
// table of directed bytes, then random frames, commands and noise.
// Depends on facd_pkg, the channel interfaces in facd_if and the RTL top.
`timescale 1ns / 1ps

module tb_frame_and_ascii_command_deframer_top;
	import facd_pkg::*;

	localparam int unsigned CycleLimit   = 60000;
	localparam int unsigned SettleCycles = 4;
	localparam int unsigned PhaseItems   = 16;
	localparam int unsigned HoldCycles   = 80;

	typedef enum logic [1:0] {
		AWAIT_START  = 2'd0,
		TAKE_LENGTH  = 2'd1,
		READ_PAYLOAD = 2'd2,
		SPARE_PHASE  = 2'd3
	} frame_state_t;

	// One byte to send; where typed is set, first and second hold the results
	// read straight off the behaviour, otherwise the predictor supplies them.
	typedef struct packed {
		byte_t      rx;
		logic       typed;
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} row_t;

	localparam result_t NoResult = '{KIND_FRAME, 8'h00, 1'b0};

	logic clk = 1'b0;
	logic arst_n;

	facd_byte_if   rx_if ();
	facd_result_if res_if ();
	facd_cfg_if    cfg_if ();

	frame_and_ascii_command_deframer_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.res    (res_if),
		.cfg    (cfg_if)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Directed bytes, frame start value 126 after reset.
	row_t opening_rows [22] = '{
		'{8'h00, 1'b1, 2'd0, NoResult, NoResult},
		'{8'hFF, 1'b1, 2'd0, NoResult, NoResult},
		'{8'h0A, 1'b1, 2'd0, NoResult, NoResult},
		'{8'h7E, 1'b1, 2'd1, '{KIND_FRAME, 8'h7E, 1'b1}, NoResult},
		'{8'h00, 1'b1, 2'd1, '{KIND_FRAME, 8'h00, 1'b1}, NoResult},
		'{8'h00, 1'b1, 2'd1, '{KIND_FRAME_END, 8'h00, 1'b1}, NoResult},
		'{8'h7E, 1'b0, 2'd0, NoResult, NoResult},
		'{8'h00, 1'b0, 2'd0, NoResult, NoResult},
		'{8'h03, 1'b0, 2'd0, NoResult, NoResult},
		'{8'hFF, 1'b0, 2'd0, NoResult, NoResult},
		'{8'h0A, 1'b0, 2'd0, NoResult, NoResult},
		'{8'h2F, 1'b0, 2'd0, NoResult, NoResult},
		'{8'h41, 1'b1, 2'd1, '{KIND_CMD_CHAR, 8'h41, 1'b1}, NoResult},
		'{8'h2F, 1'b1, 2'd2, '{KIND_CMD_DISCARD, 8'h00, 1'b0},
			'{KIND_CMD_CHAR, 8'h2F, 1'b1}},
		'{8'h0A, 1'b1, 2'd1, '{KIND_CMD_DONE, 8'h00, 1'b1}, NoResult},
		'{8'h2F, 1'b0, 2'd0, NoResult, NoResult},
		'{8'h7E, 1'b0, 2'd0, NoResult, NoResult},
		'{8'h00, 1'b0, 2'd0, NoResult, NoResult},
		'{8'h2F, 1'b0, 2'd0, NoResult, NoResult},
		'{8'hFF, 1'b0, 2'd0, NoResult, NoResult},
		'{8'h00, 1'b0, 2'd0, NoResult, NoResult},
		'{8'h0A, 1'b0, 2'd0, NoResult, NoResult}
	};

	byte_t        start_value;
	logic         cmd_open;
	frame_state_t frame_state;
	byte_t        length_high;
	logic         length_half;
	logic [15:0]  payload_left;

	result_t decoded [$];
	result_t awaited_results [$];

	int          cmd_chars_left = -1;
	logic        rx_idle_on = 1'b1;
	logic        res_idle_on = 1'b1;
	logic        hold_request = 1'b0;
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;
	row_t        step;

	function automatic result_t outcome(input kind_t kind, input byte_t data);
		result_t r;
		r.kind        = kind;
		r.data_byte   = data;
		r.last_of_run = 1'b0;
		return r;
	endfunction

	// Results of one received byte, ASCII results ahead of the frame result.
	function automatic void deframe_byte(input byte_t b);
		logic [15:0] frame_len;
		decoded = {};
		if (b == SlashChar) begin
			if (cmd_open)
				decoded = {decoded, outcome(KIND_CMD_DISCARD, 8'h00)};
			cmd_open = 1'b1;
		end
		if (cmd_open) begin
			if (b == NewlineChar) begin
				cmd_open = 1'b0;
				decoded = {decoded, outcome(KIND_CMD_DONE, 8'h00)};
			end else begin
				decoded = {decoded, outcome(KIND_CMD_CHAR, b)};
			end
		end
		case (frame_state)
			TAKE_LENGTH: begin
				if (!length_half) begin
					length_high = b;
					length_half = 1'b1;
					decoded = {decoded, outcome(KIND_FRAME, b)};
				end else begin
					frame_len   = {length_high, b};
					length_half = 1'b0;
					if (frame_len == 16'd0) begin
						frame_state = AWAIT_START;
						decoded = {decoded, outcome(KIND_FRAME_END, b)};
					end else begin
						payload_left = frame_len;
						frame_state  = READ_PAYLOAD;
						decoded = {decoded, outcome(KIND_FRAME, b)};
					end
				end
			end
			READ_PAYLOAD: begin
				payload_left = payload_left - 16'd1;
				if (payload_left == 16'd0) begin
					frame_state = AWAIT_START;
					decoded = {decoded, outcome(KIND_FRAME_END, b)};
				end else begin
					decoded = {decoded, outcome(KIND_FRAME, b)};
				end
			end
			default: begin
				if (b == start_value) begin
					frame_state = TAKE_LENGTH;
					length_half = 1'b0;
					decoded = {decoded, outcome(KIND_FRAME, b)};
				end else begin
					frame_state = AWAIT_START;
				end
			end
		endcase
		if (decoded.size() != 0)
			decoded[decoded.size() - 1].last_of_run = 1'b1;
	endfunction

	// Chooses the next random byte from the current parser state, so that any
	// frame that opens gets a short length.
	function automatic byte_t pick_byte();
		int unsigned choice;
		if (frame_state == TAKE_LENGTH) begin
			if (!length_half)
				return ($urandom_range(0, 15) == 0) ? 8'h01 : 8'h00;
			return byte_t'($urandom_range(0, 12));
		end
		if (cmd_chars_left > 0) begin
			cmd_chars_left--;
			if ($urandom_range(0, 11) == 0)
				return SlashChar;
			return byte_t'($urandom_range(8'h20, 8'h7E));
		end
		if (cmd_chars_left == 0) begin
			cmd_chars_left = -1;
			if ($urandom_range(0, 7) == 0)
				return byte_t'($urandom_range(0, 255));
			return NewlineChar;
		end
		choice = $urandom_range(0, 9);
		if (choice < 3) begin
			cmd_chars_left = $urandom_range(0, 6);
			return SlashChar;
		end
		if (choice < 6 && frame_state == AWAIT_START)
			return start_value;
		return byte_t'($urandom_range(0, 255));
	endfunction

	task automatic send_byte(input row_t r);
		int unsigned gap;
		gap = rx_idle_on ? $urandom_range(0, 12) : 0;
		if (gap != 0) begin
			rx_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_if.valid   <= 1'b1;
		rx_if.rx_byte <= r.rx;
		do @(posedge clk); while (!rx_if.ready);
		deframe_byte(r.rx);
		if (r.typed) begin
			if (r.count > 0)
				awaited_results = {awaited_results, r.first};
			if (r.count > 1)
				awaited_results = {awaited_results, r.second};
		end else begin
			foreach (decoded[i])
				awaited_results = {awaited_results, decoded[i]};
		end
	endtask

	task automatic drain_results();
		rx_if.valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
	endtask

	// A byte that gives no result may still be in flight once the queue is
	// empty, so the write also waits out SettleCycles before it is made.
	task automatic write_start_value(input byte_t value);
		drain_results();
		repeat (SettleCycles) @(posedge clk);
		cfg_if.valid             <= 1'b1;
		cfg_if.frame_start_value <= value;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		start_value = value;
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CycleLimit) begin
			$display("tb_frame_and_ascii_command_deframer_top: errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (awaited_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result: kind %0d data %02h last %0b",
						res_if.kind, res_if.data_byte, res_if.last_of_run);
			end else begin
				want = awaited_results.pop_front();
				if (res_if.kind !== want.kind || res_if.data_byte !== want.data_byte
						|| res_if.last_of_run !== want.last_of_run) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: expected %0d/%02h/%0b, got %0d/%02h/%0b",
							want.kind, want.data_byte, want.last_of_run,
							res_if.kind, res_if.data_byte, res_if.last_of_run);
				end
			end
		end
	end

	// Receiver: a random pause before each transaction, or one long hold-off
	// on request so that the block backs up and stalls its input.
	initial begin
		res_if.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			int unsigned pause;
			pause = res_idle_on ? $urandom_range(0, 12) : 0;
			if (hold_request) begin
				pause        = HoldCycles;
				hold_request = 1'b0;
			end
			if (pause != 0) begin
				res_if.ready <= 1'b0;
				repeat (pause) @(posedge clk);
			end
			res_if.ready <= 1'b1;
			do @(posedge clk); while (!res_if.valid);
		end
	end

	initial begin
		byte_t value;
		arst_n                   <= 1'b0;
		rx_if.valid              <= 1'b0;
		rx_if.rx_byte            <= 8'h00;
		cfg_if.valid             <= 1'b0;
		cfg_if.frame_start_value <= 8'h00;
		start_value  = FrameStartInit;
		cmd_open     = 1'b0;
		frame_state  = AWAIT_START;
		length_high  = 8'h00;
		length_half  = 1'b0;
		payload_left = 16'd0;
		step         = '{8'h00, 1'b0, 2'd0, NoResult, NoResult};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening_rows[i])
			send_byte(opening_rows[i]);

		for (int p = 0; p < 6; p++) begin
			case (p)
				0: value = 8'h00;
				1: value = 8'hFF;
				2: value = SlashChar;
				3: value = NewlineChar;
				4: value = byte_t'($urandom_range(0, 255));
				default: value = FrameStartInit;
			endcase
			write_start_value(value);
			rx_idle_on   = (p != 0 && p != 3);
			res_idle_on  = (p != 2 && p != 3);
			hold_request = (p == 0);
			for (int n = 0; n < PhaseItems; n++) begin
				step.rx = pick_byte();
				send_byte(step);
			end
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_frame_and_ascii_command_deframer_top: clean");
		else
			$display("tb_frame_and_ascii_command_deframer_top: errors");
		$finish;
	end

endmodule

// ===== frame_and_ascii_command_deframer_top.f =====
rtl/facd_pkg.sv
rtl/facd_if.sv
rtl/facd_parser.sv
rtl/facd_emitter.sv
rtl/frame_and_ascii_command_deframer_top.sv
dv/tb_frame_and_ascii_command_deframer_top.sv
